FILE: sv/fragment_header_parser_top_macros.svh
// Assertion macros for the fragment header parser.
`ifndef FRAGMENT_HEADER_PARSER_TOP_MACROS_SVH
`define FRAGMENT_HEADER_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define FHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FHP_ASSERT(label, prop, msg)

`define FHP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/fhp_pkg.sv
// Types, constants and helper functions of the fragment header parser.
package fhp_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int SIZE_W  = 12;
    localparam int FIELD_W = 3;

    localparam logic [FIELD_W-1:0] FLD_TOTAL   = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_NUMBER  = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_SIZE    = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_NAME    = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_PAYLOAD = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_DONE    = 3'd5;

    localparam logic [BYTE_W-1:0] SEP_CHAR   = 8'h3A;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = 12'hFFF;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              packet_start;
    } req_t;

    typedef struct packed {
        logic               item_kind;
        logic [COUNT_W-1:0] total_fragments;
        logic [COUNT_W-1:0] fragment_number;
        logic [SIZE_W-1:0]  payload_size;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last_of_packet;
        logic               size_error;
    } rsp_t;

    function automatic logic is_digit(logic [BYTE_W-1:0] b);
        return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
    endfunction

    function automatic logic is_space(logic [BYTE_W-1:0] b);
        return (b == SPACE_CHAR) || (b inside {[TAB_CHAR:CR_CHAR]});
    endfunction

    // Multiply by ten, add one digit and clamp at the given ceiling.
    function automatic logic [COUNT_W-1:0] acc_digit(logic [COUNT_W-1:0] acc,
                                                     logic [BYTE_W-1:0]  b,
                                                     logic [COUNT_W-1:0] ceil);
        logic [COUNT_W+3:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
            + {{COUNT_W{1'b0}}, b[3:0]};
        if (sum > {4'b0000, ceil})
            return ceil;
        return sum[COUNT_W-1:0];
    endfunction

endpackage

FILE: sv/fragment_header_parser_top.sv
// Top level of the fragment header parser: request register, parse logic, result register.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------
//   request | req_valid/req_stall | req (in_byte, packet_start)
//   result  | rsp_valid/rsp_stall | rsp (header fields or one byte)
//
// A request byte is taken every cycle unless req_stall is high; its result, if any, is registered
// first in the request register and then in the result register, around the parse logic.
// Reset clears the parser state and both valid flags; no clearing pass is needed.
// A stalled result holds a valid request register, and the request side then stalls too.
`include "fragment_header_parser_top_macros.svh"

module fragment_header_parser_top #(
    parameter int MAX_PAYLOAD = 1000
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fhp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fhp_pkg::rsp_t rsp
);
    import fhp_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_PAYLOAD);

    logic                s1_valid_reg;
    req_t                s1_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [FIELD_W-1:0]  fi_reg, fi_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  number_reg, number_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                ended_reg, ended_next;
    logic                seen_reg, seen_next;
    logic [SIZE_W-1:0]   left_reg, left_next;

    logic [FIELD_W-1:0]  fi_e;
    logic [COUNT_W-1:0]  total_e;
    logic [COUNT_W-1:0]  number_e;
    logic [SIZE_W-1:0]   size_e;
    logic                ended_e;
    logic                seen_e;
    logic [SIZE_W-1:0]   left_e;

    logic                can_out;
    logic                adv;
    logic                produce;
    rsp_t                result;
    logic [COUNT_W-1:0]  num_in;
    logic [COUNT_W-1:0]  num_ceil;
    logic [COUNT_W-1:0]  num_out;

    assign can_out   = !rsp_valid_reg || !rsp_stall;
    assign adv       = s1_valid_reg && can_out;
    assign req_stall = s1_valid_reg && !can_out;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A start flag clears the parser before its own byte is parsed.
    always_comb
    begin
        if (s1_reg.packet_start)
        begin
            fi_e     = FLD_TOTAL;
            total_e  = '0;
            number_e = '0;
            size_e   = '0;
            ended_e  = 1'b0;
            seen_e   = 1'b0;
            left_e   = '0;
        end
        else
        begin
            fi_e     = fi_reg;
            total_e  = total_reg;
            number_e = number_reg;
            size_e   = size_reg;
            ended_e  = ended_reg;
            seen_e   = seen_reg;
            left_e   = left_reg;
        end
    end

    always_comb
    begin
        case (fi_e)
            FLD_TOTAL:
            begin
                num_in   = total_e;
                num_ceil = COUNT_MAX;
            end
            FLD_NUMBER:
            begin
                num_in   = number_e;
                num_ceil = COUNT_MAX;
            end
            default:
            begin
                num_in   = {{(COUNT_W-SIZE_W){1'b0}}, size_e};
                num_ceil = {{(COUNT_W-SIZE_W){1'b0}}, SIZE_MAX};
            end
        endcase
        num_out = acc_digit(num_in, s1_reg.in_byte, num_ceil);
    end

    always_comb
    begin
        fi_next     = fi_e;
        total_next  = total_e;
        number_next = number_e;
        size_next   = size_e;
        ended_next  = ended_e;
        seen_next   = seen_e;
        left_next   = left_e;
        produce     = 1'b0;

        result.item_kind       = KIND_HEADER;
        result.total_fragments = total_e;
        result.fragment_number = number_e;
        result.payload_size    = size_e;
        result.payload_byte    = '0;
        result.last_of_packet  = 1'b0;
        result.size_error      = 1'b0;

        if (fi_e == FLD_PAYLOAD)
        begin
            produce               = 1'b1;
            result.item_kind      = KIND_PAYLOAD;
            result.payload_byte   = s1_reg.in_byte;
            result.last_of_packet = (left_e <= SIZE_W'(1));
            if (left_e <= SIZE_W'(1))
            begin
                left_next = '0;
                fi_next   = FLD_DONE;
            end
            else
            begin
                left_next = left_e - SIZE_W'(1);
            end
        end
        else if (fi_e < FLD_PAYLOAD)
        begin
            if (s1_reg.in_byte == SEP_CHAR)
            begin
                ended_next = 1'b0;
                seen_next  = 1'b0;
                if (fi_e == FLD_NAME)
                begin
                    produce = 1'b1;
                    if (size_e > MAX_SIZE)
                    begin
                        result.last_of_packet = 1'b1;
                        result.size_error     = 1'b1;
                        fi_next               = FLD_DONE;
                    end
                    else if (size_e == '0)
                    begin
                        result.last_of_packet = 1'b1;
                        fi_next               = FLD_DONE;
                    end
                    else
                    begin
                        left_next = size_e;
                        fi_next   = FLD_PAYLOAD;
                    end
                end
                else
                begin
                    fi_next = fi_e + FIELD_W'(1);
                end
            end
            else if (fi_e != FLD_NAME && !ended_e)
            begin
                if (is_digit(s1_reg.in_byte))
                begin
                    seen_next = 1'b1;
                    case (fi_e)
                        FLD_TOTAL:  total_next  = num_out;
                        FLD_NUMBER: number_next = num_out;
                        default:    size_next   = num_out[SIZE_W-1:0];
                    endcase
                end
                else if (!(is_space(s1_reg.in_byte) && !seen_e))
                begin
                    ended_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fi_reg        <= FLD_TOTAL;
            total_reg     <= '0;
            number_reg    <= '0;
            size_reg      <= '0;
            ended_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (!req_stall)
                s1_valid_reg <= req_valid;
            if (can_out)
                rsp_valid_reg <= adv && produce;
            if (adv)
            begin
                fi_reg     <= fi_next;
                total_reg  <= total_next;
                number_reg <= number_next;
                size_reg   <= size_next;
                ended_reg  <= ended_next;
                seen_reg   <= seen_next;
                left_reg   <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_reg <= req;
        if (adv && produce)
            rsp_reg <= result;
    end

    `FHP_ASSERT(a_payload_left, (fi_reg == FLD_PAYLOAD) |-> (left_reg != '0), "payload count ran out before the last byte")
    `FHP_ASSERT(a_done_clear, (fi_reg == FLD_DONE) |-> (left_reg == '0), "payload count left over after the packet")
    `FHP_ASSERT(a_err_last, (rsp_valid && rsp.size_error) |-> (rsp.last_of_packet && (rsp.item_kind == KIND_HEADER)), "size error on a result that does not end the packet")
    `FHP_ASSERT_NEXT(a_last_done, (adv && produce && result.last_of_packet && !s1_reg.packet_start), (fi_reg == FLD_DONE), "parser not done after the last result")

endmodule
